// ----- rtl/button_chord_key_event_generator_unit_defines.svh -----
// Assertion macros shared by the RTL.
`ifndef BUTTON_CHORD_KEY_EVENT_GENERATOR_UNIT_DEFINES_SVH
`define BUTTON_CHORD_KEY_EVENT_GENERATOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BCKE_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define BCKE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/bcke_pkg.sv -----
package bcke_pkg;

	localparam int NUM_BUTTONS  = 7;
	localparam int MAX_EVENTS   = 8;
	localparam int EV_IDX_W     = 3;
	localparam int EV_CNT_W     = 4;
	localparam int QUEUE_DEPTH  = 4;
	localparam int QUEUE_PTR_W  = 2;
	localparam int QUEUE_CNT_W  = 3;
	localparam int PADDR_W      = 3;
	localparam int PDATA_W      = 32;
	localparam int DEBOUNCE_W   = 4;

	localparam logic [0:0] REG_DEBOUNCE_COUNT = 1'b0;
	localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 4'd2;

	localparam int BTN_DPAD_LAST = 3;
	localparam int BTN_MIDDLE    = 4;
	localparam int BTN_A         = 5;
	localparam int BTN_B         = 6;

	typedef logic [3:0] key_code_t;

	localparam key_code_t KEY_SPACE  = 4'd4;
	localparam key_code_t KEY_RETURN = 4'd5;
	localparam key_code_t KEY_LCTRL  = 4'd6;
	localparam key_code_t KEY_LALT   = 4'd7;
	localparam key_code_t KEY_ESCAPE = 4'd8;
	localparam key_code_t CODE_NONE  = 4'd15;

	typedef struct packed {
		logic [NUM_BUTTONS-1:0] raw_buttons;
		logic                   in_game;
	} in_word_t;

	typedef struct packed {
		key_code_t key_code;
		logic      key_down;
		logic      last_of_poll;
	} out_word_t;

	typedef struct packed {
		key_code_t code;
		logic      down;
	} event_t;

	typedef struct packed {
		event_t [MAX_EVENTS-1:0] events;
		logic [EV_IDX_W-1:0]     last_idx;
	} poll_entry_t;

	typedef struct packed {
		logic primed;
		logic has_events;
	} front_status_t;

	typedef struct packed {
		logic mid_poll;
		logic take;
	} back_status_t;

endpackage

// ----- rtl/bcke_front.sv -----
module bcke_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bcke_pkg::in_word_t            in_word,
	input  logic                          accept,
	input  logic [bcke_pkg::DEBOUNCE_W-1:0] debounce_count,
	output bcke_pkg::poll_entry_t         entry,
	output bcke_pkg::front_status_t       status
);

	logic                                              primed_q;
	logic [bcke_pkg::NUM_BUTTONS-1:0]                  stable_q;
	logic [bcke_pkg::NUM_BUTTONS-1:0][bcke_pkg::DEBOUNCE_W-1:0] cnt_q;
	bcke_pkg::key_code_t [bcke_pkg::NUM_BUTTONS-1:0]   held_q;
	logic                                              modflag_q;

	logic [bcke_pkg::NUM_BUTTONS-1:0]                  stable_n;
	logic [bcke_pkg::NUM_BUTTONS-1:0][bcke_pkg::DEBOUNCE_W-1:0] cnt_n;
	bcke_pkg::key_code_t [bcke_pkg::NUM_BUTTONS-1:0]   held_n;
	logic                                              modflag_n;
	logic [bcke_pkg::NUM_BUTTONS-1:0]                  pressed;
	logic [bcke_pkg::NUM_BUTTONS-1:0]                  released;
	logic [bcke_pkg::EV_CNT_W-1:0]                     n_events;
	logic [bcke_pkg::EV_CNT_W-1:0]                     n_minus1;

	always_comb begin
		logic [bcke_pkg::DEBOUNCE_W-1:0] inc;
		logic [bcke_pkg::NUM_BUTTONS-1:0] flip;
		flip = '0;
		for (int i = 0; i < bcke_pkg::NUM_BUTTONS; i++) begin
			inc = cnt_q[i] + 4'd1;
			if (in_word.raw_buttons[i] == stable_q[i]) begin
				cnt_n[i] = '0;
			end else if (inc < debounce_count) begin
				cnt_n[i] = inc;
			end else begin
				cnt_n[i] = '0;
				flip[i] = 1'b1;
			end
		end
		stable_n = stable_q ^ flip;
		pressed  = stable_n & ~stable_q;
		released = ~stable_n & stable_q;
		modflag_n = (pressed[bcke_pkg::BTN_MIDDLE] ? 1'b0 : modflag_q)
			| ((pressed[bcke_pkg::BTN_A] | pressed[bcke_pkg::BTN_B])
				& stable_n[bcke_pkg::BTN_MIDDLE]);
	end

	always_comb begin
		logic center;
		center = stable_n[bcke_pkg::BTN_MIDDLE];
		for (int i = 0; i < bcke_pkg::NUM_BUTTONS; i++) begin
			held_n[i] = held_q[i];
			if (released[i]) begin
				held_n[i] = bcke_pkg::CODE_NONE;
			end
			if (pressed[i]) begin
				if (i <= bcke_pkg::BTN_DPAD_LAST) begin
					held_n[i] = 4'(i);
				end else if (i == bcke_pkg::BTN_A) begin
					held_n[i] = !in_word.in_game ? bcke_pkg::KEY_ESCAPE :
						(center ? bcke_pkg::KEY_LCTRL : bcke_pkg::KEY_RETURN);
				end else if (i == bcke_pkg::BTN_B) begin
					held_n[i] = (in_word.in_game && center) ? bcke_pkg::KEY_LALT :
						bcke_pkg::KEY_SPACE;
				end
			end
		end
	end

	// Events are packed in button order into consecutive slots.
	always_comb begin
		logic [bcke_pkg::EV_CNT_W-1:0] cnt;
		logic [bcke_pkg::EV_IDX_W-1:0] idx1;
		bcke_pkg::key_code_t           ctr_code;
		cnt = '0;
		ctr_code = in_word.in_game ? bcke_pkg::KEY_ESCAPE : bcke_pkg::KEY_RETURN;
		entry.events = '0;
		for (int i = 0; i < bcke_pkg::NUM_BUTTONS; i++) begin
			idx1 = cnt[bcke_pkg::EV_IDX_W-1:0] + 3'd1;
			if (pressed[i] && i != bcke_pkg::BTN_MIDDLE) begin
				entry.events[cnt[bcke_pkg::EV_IDX_W-1:0]].code = held_n[i];
				entry.events[cnt[bcke_pkg::EV_IDX_W-1:0]].down = 1'b1;
				cnt = cnt + 4'd1;
			end
			if (released[i]) begin
				if (i == bcke_pkg::BTN_MIDDLE) begin
					if (!modflag_q) begin
						entry.events[cnt[bcke_pkg::EV_IDX_W-1:0]].code = ctr_code;
						entry.events[cnt[bcke_pkg::EV_IDX_W-1:0]].down = 1'b1;
						entry.events[idx1].code = ctr_code;
						entry.events[idx1].down = 1'b0;
						cnt = cnt + 4'd2;
					end
				end else if (held_q[i] != bcke_pkg::CODE_NONE) begin
					entry.events[cnt[bcke_pkg::EV_IDX_W-1:0]].code = held_q[i];
					entry.events[cnt[bcke_pkg::EV_IDX_W-1:0]].down = 1'b0;
					cnt = cnt + 4'd1;
				end
			end
		end
		n_events = cnt;
	end

	assign n_minus1          = n_events - 4'd1;
	assign entry.last_idx    = n_minus1[bcke_pkg::EV_IDX_W-1:0];
	assign status.primed     = primed_q;
	assign status.has_events = primed_q && (n_events != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q  <= 1'b0;
			stable_q  <= '0;
			cnt_q     <= '0;
			held_q    <= {bcke_pkg::NUM_BUTTONS{bcke_pkg::CODE_NONE}};
			modflag_q <= 1'b0;
		end else if (accept) begin
			if (!primed_q) begin
				primed_q <= 1'b1;
				stable_q <= in_word.raw_buttons;
			end else begin
				stable_q  <= stable_n;
				cnt_q     <= cnt_n;
				held_q    <= held_n;
				modflag_q <= modflag_n;
			end
		end
	end

endmodule

// ----- rtl/bcke_queue.sv -----
module bcke_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  bcke_pkg::poll_entry_t wr_entry,
	output logic                  full,
	input  logic                  rd_en,
	output bcke_pkg::poll_entry_t rd_entry,
	output logic                  valid
);

	bcke_pkg::poll_entry_t               mem [bcke_pkg::QUEUE_DEPTH];
	logic [bcke_pkg::QUEUE_PTR_W-1:0]    wptr_q;
	logic [bcke_pkg::QUEUE_PTR_W-1:0]    rptr_q;
	logic [bcke_pkg::QUEUE_CNT_W-1:0]    count_q;

	assign full     = count_q == bcke_pkg::QUEUE_CNT_W'(bcke_pkg::QUEUE_DEPTH);
	assign valid    = count_q != '0;
	assign rd_entry = mem[rptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (wr_en) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (rd_en) begin
				rptr_q <= rptr_q + 1'b1;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- rtl/bcke_back.sv -----
module bcke_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  bcke_pkg::poll_entry_t   entry,
	input  logic                    q_valid,
	output logic                    q_pop,
	input  logic                    pop,
	output logic                    empty,
	output bcke_pkg::out_word_t     out_word,
	output bcke_pkg::back_status_t  status
);

	logic [bcke_pkg::EV_IDX_W-1:0] idx_q;
	logic                          out_valid_q;
	bcke_pkg::out_word_t           out_q;
	logic                          take;
	logic                          last;

	assign take  = q_valid && (!out_valid_q || pop);
	assign last  = idx_q == entry.last_idx;
	assign q_pop = take && last;

	assign empty           = !out_valid_q;
	assign out_word        = out_q;
	assign status.mid_poll = idx_q != '0;
	assign status.take     = take;

	always_ff @(posedge clk) begin
		if (take) begin
			out_q.key_code     <= entry.events[idx_q].code;
			out_q.key_down     <= entry.events[idx_q].down;
			out_q.last_of_poll <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				idx_q       <= last ? '0 : idx_q + 3'd1;
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- rtl/button_chord_key_event_generator_unit.sv -----
// Debounced seven-button keypad that turns polls into key press and release events.
// Input channel: a poll word (raw buttons, game-or-menu flag) is taken when push is high
// and full is low. A new poll can be taken every cycle while the poll queue has room.
// Output channel: the oldest event word sits on out_word while empty is low and leaves
// when pop is high. Each poll yields zero to eight events; the last one carries
// last_of_poll. While pop is high, events leave a registered output stage one per cycle.
// The events of a poll pass through the poll queue and then the registered output stage;
// a poll with n events holds the output side until the last of them has been taken.
// The front classifies polls and updates the debounce and held-key state in the cycle a
// poll is taken; a four-entry queue holds the events of waiting polls.
// When the receiver stalls, the output word holds, the queue fills and full rises.
// Reset empties the queue, clears all debounce state and sets the debounce count to two;
// the first poll after reset only loads the stable button state. The debounce count is
// written over the APB port at byte address zero by users only while idle, unenforced.
`include "button_chord_key_event_generator_unit_defines.svh"

module button_chord_key_event_generator_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  bcke_pkg::in_word_t            in_word,
	input  logic                          pop,
	output logic                          empty,
	output bcke_pkg::out_word_t           out_word,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bcke_pkg::PADDR_W-1:0]  paddr,
	input  logic [bcke_pkg::PDATA_W-1:0]  pwdata,
	output logic [bcke_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);

	logic [bcke_pkg::DEBOUNCE_W-1:0] debounce_q;
	logic                            accept;
	logic                            q_push;
	logic                            q_pop;
	logic                            q_valid;
	logic                            sel_debounce;
	bcke_pkg::poll_entry_t           front_entry;
	bcke_pkg::poll_entry_t           head_entry;
	bcke_pkg::front_status_t         front_status;
	bcke_pkg::back_status_t          back_status;

	assign pready       = 1'b1;
	assign sel_debounce = paddr[bcke_pkg::PADDR_W-1:2] == bcke_pkg::REG_DEBOUNCE_COUNT;
	assign prdata       = sel_debounce ? bcke_pkg::PDATA_W'(debounce_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= bcke_pkg::DEBOUNCE_RESET;
		end else if (psel && penable && pwrite && pready && sel_debounce) begin
			debounce_q <= pwdata[bcke_pkg::DEBOUNCE_W-1:0];
		end
	end

	assign accept = push && !full;
	assign q_push = accept && front_status.has_events;

	bcke_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_word        (in_word),
		.accept         (accept),
		.debounce_count (debounce_q),
		.entry          (front_entry),
		.status         (front_status)
	);

	bcke_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (q_push),
		.wr_entry (front_entry),
		.full     (full),
		.rd_en    (q_pop),
		.rd_entry (head_entry),
		.valid    (q_valid)
	);

	bcke_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.entry    (head_entry),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.pop      (pop),
		.empty    (empty),
		.out_word (out_word),
		.status   (back_status)
	);

	`BCKE_ASSERT_IMP(a_push_only_primed, q_push, front_status.primed, "Events queued before priming.")
	`BCKE_ASSERT_IMP(a_mid_poll_has_entry, back_status.mid_poll, q_valid, "Partial poll without a queue entry.")
	`BCKE_ASSERT_NEXT(a_take_fills_output, back_status.take, !empty, "Event taken but output stage empty.")

endmodule
